// ===== hw/rtl/eht_pkg.sv =====
// eht_pkg: shared types, constants and slot arithmetic for the epoch history table
// used by eht_mem, eht_ctrl and epoch_history_table; depends on nothing else
package eht_pkg;

   localparam int DEPTH = 16;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CFG_W = 5;
   localparam int VAL_W = 64;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [CNT_W-1:0] cnt_type;

   localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(16);

   // opcodes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_TRIM   = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // result status codes
   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_MISORDER  = 2'd1;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [1:0]       opcode;
      logic [VAL_W-1:0] epoch_value;
      logic [VAL_W-1:0] sequence_value;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [VAL_W-1:0] found_epoch;
   } rsp_type;

   typedef struct packed {
      logic [VAL_W-1:0] epoch;
      logic [VAL_W-1:0] first_seq;
   } entry_type;

   typedef struct packed {
      logic      rd_en;
      idx_type   rd_addr;
      logic      wr_en;
      idx_type   wr_addr;
      entry_type wr_data;
   } mem_req_type;

   // ring slot that lies off places after base; base < DEPTH, off <= DEPTH
   function automatic idx_type slot_add(idx_type base, cnt_type off);
      logic [CNT_W:0] sum;
      sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
      if (sum >= (CNT_W+1)'(DEPTH)) begin
         sum = sum - (CNT_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/eht_mem.sv =====
// eht_mem: entry storage of the history table, one write and one registered read port
// depends on eht_pkg for the entry and request types
module eht_mem (
   input  logic                 clock,
   input  eht_pkg::mem_req_type mem_req,
   output eht_pkg::entry_type   rd_data
);

   eht_pkg::entry_type mem_array [eht_pkg::DEPTH];
   eht_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem_array[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem_array[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/eht_ctrl.sv =====
// eht_ctrl: sequencer for add, trim and lookup over the entry memory, ring pointers
// depends on eht_pkg; drives eht_mem through a mem_req_type struct
module eht_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  eht_pkg::req_type         req_data,
   input  logic [eht_pkg::CFG_W-1:0] max_entries,
   output logic                     res_valid,
   input  logic                     res_ready,
   output eht_pkg::rsp_type         res_data,
   output eht_pkg::mem_req_type     mem_req,
   input  eht_pkg::entry_type       rd_data
);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_ADD_CHK   = 5'b00010,
      ST_TRIM_CHK  = 5'b00100,
      ST_LOOK_CHK  = 5'b01000,
      ST_RESP      = 5'b10000
   } state_type;

   state_type                     state_ff, state_in;
   eht_pkg::idx_type              oldest_ff, oldest_in;
   eht_pkg::cnt_type              count_ff, count_in;
   logic [eht_pkg::VAL_W-1:0]     epoch_ff, epoch_in;
   logic [eht_pkg::VAL_W-1:0]     seq_ff, seq_in;
   eht_pkg::cnt_type              lo_ff, lo_in;
   eht_pkg::cnt_type              hi_ff, hi_in;
   eht_pkg::idx_type              mid_ff, mid_in;
   eht_pkg::rsp_type              res_ff, res_in;
   eht_pkg::cnt_type              limit;

   // limit clamped to 1..DEPTH
   always_comb begin
      if (max_entries == '0) begin
         limit = eht_pkg::CNT_W'(1);
      end else if (32'(max_entries) > eht_pkg::DEPTH) begin
         limit = eht_pkg::CNT_W'(eht_pkg::DEPTH);
      end else begin
         limit = eht_pkg::CNT_W'(max_entries);
      end
   end

   always_comb begin
      logic                  add_ok;
      eht_pkg::cnt_type      keep;
      eht_pkg::idx_type      oldest_new;
      eht_pkg::cnt_type      lo_new;
      eht_pkg::cnt_type      hi_new;
      logic [eht_pkg::CNT_W:0] mid_sum;

      state_in   = state_ff;
      oldest_in  = oldest_ff;
      count_in   = count_ff;
      epoch_in   = epoch_ff;
      seq_in     = seq_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      mid_in     = mid_ff;
      res_in     = res_ff;
      mem_req    = '0;
      res_valid  = 1'b0;
      add_ok     = 1'b0;
      keep       = count_ff;
      oldest_new = oldest_ff;
      lo_new     = lo_ff;
      hi_new     = hi_ff;
      mid_sum    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               epoch_in = req_data.epoch_value;
               seq_in   = req_data.sequence_value;
               res_in   = '0;
               unique case (req_data.opcode)
                  eht_pkg::OP_ADD: begin
                     // fetch the newest entry for the order check
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = eht_pkg::slot_add(oldest_ff,
                        (count_ff == '0) ? '0 : count_ff - eht_pkg::CNT_W'(1));
                     state_in = ST_ADD_CHK;
                  end
                  eht_pkg::OP_TRIM: begin
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = oldest_ff;
                     state_in = ST_TRIM_CHK;
                  end
                  eht_pkg::OP_LOOKUP: begin
                     res_in.status   = eht_pkg::STAT_NOT_FOUND;
                     lo_in           = '0;
                     hi_in           = count_ff;
                     mid_in          = eht_pkg::IDX_W'(count_ff >> 1);
                     mem_req.rd_en   = 1'b1;
                     mem_req.rd_addr = eht_pkg::slot_add(oldest_ff,
                        eht_pkg::CNT_W'(count_ff >> 1));
                     state_in = (count_ff == '0) ? ST_RESP : ST_LOOK_CHK;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end

         ST_ADD_CHK: begin
            add_ok = (count_ff == '0) ||
                     ((epoch_ff > rd_data.epoch) && (seq_ff > rd_data.first_seq));
            if (add_ok) begin
               // evict down to limit-1 entries in one step
               if (count_ff >= limit) begin
                  keep       = limit - eht_pkg::CNT_W'(1);
                  oldest_new = eht_pkg::slot_add(oldest_ff, count_ff - keep);
               end
               mem_req.wr_en         = 1'b1;
               mem_req.wr_addr       = eht_pkg::slot_add(oldest_new, keep);
               mem_req.wr_data.epoch = epoch_ff;
               mem_req.wr_data.first_seq = seq_ff;
               oldest_in = oldest_new;
               count_in  = keep + eht_pkg::CNT_W'(1);
            end else begin
               res_in.status = eht_pkg::STAT_MISORDER;
            end
            state_in = ST_RESP;
         end

         ST_TRIM_CHK: begin
            if ((count_ff != '0) && (rd_data.epoch < epoch_ff)) begin
               // pop one and fetch the next oldest in the same cycle
               oldest_new      = eht_pkg::slot_add(oldest_ff, eht_pkg::CNT_W'(1));
               oldest_in       = oldest_new;
               count_in        = count_ff - eht_pkg::CNT_W'(1);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = oldest_new;
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_LOOK_CHK: begin
            // first sequences rise from oldest to newest, so bisect
            if (rd_data.first_seq <= seq_ff) begin
               lo_new             = eht_pkg::CNT_W'(mid_ff) + eht_pkg::CNT_W'(1);
               res_in.status      = eht_pkg::STAT_OK;
               res_in.found_epoch = rd_data.epoch;
            end else begin
               hi_new = eht_pkg::CNT_W'(mid_ff);
            end
            lo_in   = lo_new;
            hi_in   = hi_new;
            mid_sum = ((eht_pkg::CNT_W+1)'(lo_new) + (eht_pkg::CNT_W+1)'(hi_new)) >> 1;
            if (lo_new < hi_new) begin
               mid_in          = mid_sum[eht_pkg::IDX_W-1:0];
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = eht_pkg::slot_add(oldest_ff,
                  mid_sum[eht_pkg::CNT_W-1:0]);
            end else begin
               state_in = ST_RESP;
            end
         end

         ST_RESP: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         oldest_ff <= '0;
         count_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         oldest_ff <= oldest_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      epoch_ff <= epoch_in;
      seq_ff   <= seq_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      res_ff   <= res_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_data  = res_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= eht_pkg::CNT_W'(eht_pkg::DEPTH))
      else $error("entry count beyond table depth");

   a_write_only_on_add: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff == ST_ADD_CHK))
      else $error("memory write outside add check");

   a_count_grows_on_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ADD_CHK) |=> (count_ff <= $past(count_ff)))
      else $error("entry count grew outside an add");

   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK_CHK) |-> ((lo_ff < hi_ff) && (hi_ff <= count_ff) &&
                                     (eht_pkg::CNT_W'(mid_ff) < hi_ff)))
      else $error("lookup probe outside search window");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("sequencer idle right after a request transfer");
`endif

endmodule

// ===== hw/rtl/epoch_history_table.sv =====
// epoch_history_table: top level with config register, output register and instances
// depends on eht_pkg, eht_mem and eht_ctrl

// Bounded history of (epoch, first sequence) pairs held in a ring of DEPTH entries in a
// synchronous memory with one write and one registered read port; one item is worked at
// a time. Between the request transfer and the result in the output register, add reads
// the newest entry and checks it, trim reads and drops the oldest entry one step at a
// time, and lookup makes one bisection probe per step (at most clog2(DEPTH)+1 probes);
// a lookup on an empty table goes straight to the result. A new request is taken as
// soon as the previous result has moved into the output register. Writes to
// max_entries take effect on the next add; a limit of 0 acts as 1 and values above
// DEPTH act as DEPTH. After reset the table is empty and needs no clearing pass.
module epoch_history_table (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  eht_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output eht_pkg::rsp_type          rsp_data,
   input  logic                      csr_wr_en,
   input  logic [eht_pkg::CFG_W-1:0] csr_wr_data
);

   logic [eht_pkg::CFG_W-1:0] max_entries_ff, max_entries_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   eht_pkg::rsp_type          rsp_data_ff, rsp_data_in;

   logic                 res_valid;
   logic                 res_ready;
   eht_pkg::rsp_type     res_data;
   eht_pkg::mem_req_type mem_req;
   eht_pkg::entry_type   rd_data;

   eht_mem u_mem (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   eht_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .max_entries (max_entries_ff),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res_data    (res_data),
      .mem_req     (mem_req),
      .rd_data     (rd_data)
   );

   // output slot frees when empty or when its transfer happens this cycle
   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      max_entries_in = csr_wr_en ? csr_wr_data : max_entries_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_data;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_entries_ff <= eht_pkg::MAX_ENTRIES_RESET;
         rsp_valid_ff   <= 1'b0;
      end else begin
         max_entries_ff <= max_entries_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== bench/tb_epoch_history_table.sv =====
// tb_epoch_history_table: self-checking bench for the epoch history table top level
// holds a history scoreboard class that predicts each result; depends on eht_pkg and the rtl
module tb_epoch_history_table;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0]                OP_UNUSED      = 2'd3;
   localparam logic [eht_pkg::VAL_W-1:0] ALL_ONES       = '1;
   localparam int                        WATCHDOG_LIMIT = 2000;
   localparam int                        SETTLE_CYCLES  = 25;
   localparam int                        PHASE_ITEMS    = 200;
   localparam int                        PHASE_COUNT    = 8;

   // predicts each result from its own copy of the ring and the limit register
   class history_scoreboard;
      logic [eht_pkg::VAL_W-1:0] epochs [eht_pkg::DEPTH];
      logic [eht_pkg::VAL_W-1:0] seqs [eht_pkg::DEPTH];
      int                        oldest;
      int                        count;
      logic [eht_pkg::CFG_W-1:0] limit_reg;
      eht_pkg::rsp_type          pending_results[$];
      int                        errors;
      int                        adds_taken, adds_refused, trims, entries_dropped;
      int                        lookups_hit, lookups_missed, results_checked, limits_written;

      function void clear();
         oldest    = 0;
         count     = 0;
         limit_reg = eht_pkg::MAX_ENTRIES_RESET;
         pending_results.delete();
      endfunction

      function void set_limit(logic [eht_pkg::CFG_W-1:0] value);
         limit_reg = value;
         limits_written++;
      endfunction

      function int slot(int logical);
         return (oldest + logical) % eht_pkg::DEPTH;
      endfunction

      function logic [eht_pkg::VAL_W-1:0] epoch_at(int logical);
         return epochs[slot(logical)];
      endfunction

      function logic [eht_pkg::VAL_W-1:0] seq_at(int logical);
         return seqs[slot(logical)];
      endfunction

      function void drop_oldest();
         oldest = (oldest + 1) % eht_pkg::DEPTH;
         count--;
         entries_dropped++;
      endfunction

      function void predict_request(eht_pkg::req_type req);
         eht_pkg::rsp_type want;
         int               lim;
         int               i;
         want = '0;
         case (req.opcode)
            eht_pkg::OP_ADD: begin
               if (count > 0 && !(req.epoch_value > epochs[slot(count - 1)] &&
                                  req.sequence_value > seqs[slot(count - 1)])) begin
                  want.status = eht_pkg::STAT_MISORDER;
                  adds_refused++;
               end else begin
                  lim = int'(limit_reg);
                  if (lim < 1) lim = 1;
                  if (lim > eht_pkg::DEPTH) lim = eht_pkg::DEPTH;
                  while (count >= lim) drop_oldest();
                  epochs[slot(count)] = req.epoch_value;
                  seqs[slot(count)]   = req.sequence_value;
                  count++;
                  adds_taken++;
               end
            end
            eht_pkg::OP_TRIM: begin
               trims++;
               while (count > 0 && epochs[oldest] < req.epoch_value) drop_oldest();
            end
            eht_pkg::OP_LOOKUP: begin
               want.status = eht_pkg::STAT_NOT_FOUND;
               for (i = count - 1; i >= 0; i--) begin
                  if (seqs[slot(i)] <= req.sequence_value) begin
                     want.status      = eht_pkg::STAT_OK;
                     want.found_epoch = epochs[slot(i)];
                     break;
                  end
               end
               if (want.status == eht_pkg::STAT_OK) lookups_hit++;
               else lookups_missed++;
            end
            default: ;
         endcase
         pending_results = {pending_results, want};
      endfunction

      function void check_result(eht_pkg::rsp_type got);
         eht_pkg::rsp_type want;
         if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d, found_epoch %0h",
                   got.status, got.found_epoch);
            errors++;
            return;
         end
         want = pending_results[0];
         pending_results.delete(0);
         results_checked++;
         if (got.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.found_epoch !== want.found_epoch) begin
            $error("found_epoch mismatch: expected %0h, actual %0h",
                   want.found_epoch, got.found_epoch);
            errors++;
         end
      endfunction
   endclass

   logic                      clock;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_ready;
   eht_pkg::req_type          req_data    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready   = 1'b1;
   eht_pkg::rsp_type          rsp_data;
   logic                      csr_wr_en   = 1'b0;
   logic [eht_pkg::CFG_W-1:0] csr_wr_data = '0;

   history_scoreboard sb;
   int                send_idle_pct;
   int                stall_pct;
   bit                quiet_tail;
   int                idle_cycles;

   epoch_history_table dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // result side: check every transfer against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         sb.check_result(rsp_data);
      end
   end

   // receiver stalls in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready === 1'b1) || (rsp_valid === 1'b1 && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("epoch_history_table test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_request(input eht_pkg::req_type item);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.predict_request(item);
   endtask

   task automatic sender_pause();
      if (!quiet_tail && $urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   task automatic send_op(input logic [1:0] op, input logic [eht_pkg::VAL_W-1:0] ep,
                          input logic [eht_pkg::VAL_W-1:0] sq);
      eht_pkg::req_type item;
      item.opcode         = op;
      item.epoch_value    = ep;
      item.sequence_value = sq;
      send_request(item);
      sender_pause();
   endtask

   // hold off until every result is back and the block has settled
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [eht_pkg::CFG_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_limit(value);
   endtask

   function automatic logic [eht_pkg::VAL_W-1:0] random_step();
      if ($urandom_range(0, 9) == 0) return {32'h0, $urandom};
      return eht_pkg::VAL_W'($urandom_range(1, 1000));
   endfunction

   // mostly adds, most in order to grow the history, with lookups and trims aimed at it
   function automatic eht_pkg::req_type random_request();
      eht_pkg::req_type          r;
      int                        n;
      int                        pick;
      logic [eht_pkg::VAL_W-1:0] ne, ns;
      n  = sb.count;
      ne = '0;
      ns = '0;
      if (n > 0) begin
         ne = sb.epoch_at(n - 1);
         ns = sb.seq_at(n - 1);
      end
      r.opcode         = eht_pkg::OP_ADD;
      r.epoch_value    = {$urandom, $urandom};
      r.sequence_value = {$urandom, $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
         if (n > 0 && $urandom_range(0, 39) != 0) begin
            r.epoch_value    = ne + random_step();
            r.sequence_value = ns + random_step();
         end
      end else if (pick < 60) begin
         case ($urandom_range(0, 2))
            0: begin
               r.epoch_value    = ne;
               r.sequence_value = ns + random_step();
            end
            1: begin
               r.epoch_value    = ne + random_step();
               r.sequence_value = ns - eht_pkg::VAL_W'($urandom_range(0, 50));
            end
            default: begin
               r.epoch_value    = ne - eht_pkg::VAL_W'($urandom_range(1, 50));
               r.sequence_value = ns + random_step();
            end
         endcase
      end else if (pick < 84) begin
         r.opcode = eht_pkg::OP_LOOKUP;
         if (n > 0 && $urandom_range(0, 4) != 0) begin
            r.sequence_value = sb.seq_at($urandom_range(0, n - 1)) +
                               eht_pkg::VAL_W'($urandom_range(0, 2)) - eht_pkg::VAL_W'(1);
         end
      end else if (pick < 96) begin
         r.opcode = eht_pkg::OP_TRIM;
         if ($urandom_range(0, 9) == 0) begin
            r.epoch_value = ALL_ONES;
         end else if (n > 0) begin
            r.epoch_value = sb.epoch_at($urandom_range(0, n - 1)) +
                            eht_pkg::VAL_W'($urandom_range(0, 1));
         end
      end else begin
         r.opcode = OP_UNUSED;
      end
      // an accepted epoch of all ones could never be passed or trimmed away
      if (r.opcode == eht_pkg::OP_ADD && r.epoch_value == ALL_ONES) begin
         r.epoch_value = ALL_ONES - 1;
      end
      return r;
   endfunction

   initial begin
      logic [eht_pkg::CFG_W-1:0] phase_limits [PHASE_COUNT];
      int                        p;
      sb = new;
      sb.clear();
      send_idle_pct = 20;
      stall_pct     = 20;
      quiet_tail    = 1'b0;
      idle_cycles   = 0;
      phase_limits  = '{5'd16, 5'd1, 5'd31, 5'd5, 5'd0, 5'd2, 5'd17, 5'd16};
      phase_limits[5] = eht_pkg::CFG_W'($urandom_range(0, 31));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      write_limit(eht_pkg::MAX_ENTRIES_RESET);

      // empty table, misordered adds, extreme values and trims
      send_op(eht_pkg::OP_LOOKUP, '0, '0);
      send_op(eht_pkg::OP_TRIM, ALL_ONES, '0);
      send_op(OP_UNUSED, ALL_ONES, ALL_ONES);
      send_op(eht_pkg::OP_ADD, '0, '0);
      send_op(eht_pkg::OP_ADD, '0, 64'd9);
      send_op(eht_pkg::OP_ADD, 64'd9, '0);
      send_op(eht_pkg::OP_ADD, 64'd10, 64'd10);
      send_op(eht_pkg::OP_LOOKUP, '0, 64'd9);
      send_op(eht_pkg::OP_LOOKUP, '0, 64'd10);
      send_op(eht_pkg::OP_ADD, ALL_ONES - 1, ALL_ONES);
      send_op(eht_pkg::OP_ADD, ALL_ONES, 64'd5);
      send_op(eht_pkg::OP_LOOKUP, '0, ALL_ONES);
      send_op(eht_pkg::OP_TRIM, 64'd10, '0);
      send_op(eht_pkg::OP_LOOKUP, ALL_ONES, 64'd5);
      send_op(eht_pkg::OP_TRIM, ALL_ONES, ALL_ONES);
      send_op(eht_pkg::OP_LOOKUP, '0, ALL_ONES);

      // small limit: a full table evicts its oldest entry
      wait_drained();
      write_limit(5'd3);
      send_op(eht_pkg::OP_ADD, 64'd1, 64'd1);
      send_op(eht_pkg::OP_ADD, 64'd2, 64'd2);
      send_op(eht_pkg::OP_ADD, 64'd3, 64'd3);
      send_op(eht_pkg::OP_ADD, 64'd4, 64'd4);
      send_op(eht_pkg::OP_LOOKUP, '0, 64'd1);
      send_op(eht_pkg::OP_LOOKUP, '0, 64'd3);

      // limit of zero acts as one: the next add evicts several entries
      wait_drained();
      write_limit(5'd0);
      send_op(eht_pkg::OP_ADD, 64'd5, 64'd5);
      send_op(eht_pkg::OP_LOOKUP, '0, 64'd4);
      send_op(eht_pkg::OP_LOOKUP, '0, ALL_ONES);

      for (p = 0; p < PHASE_COUNT; p++) begin
         wait_drained();
         write_limit(phase_limits[p]);
         case (p % 3)
            0:       begin send_idle_pct = 25; stall_pct = 0;  end
            1:       begin send_idle_pct = 0;  stall_pct = 25; end
            default: begin send_idle_pct = 8;  stall_pct = 8;  end
         endcase
         if (p == PHASE_COUNT - 1) quiet_tail = 1'b1;
         repeat (PHASE_ITEMS) begin
            send_request(random_request());
            sender_pause();
         end
      end
      wait_drained();

      $display("checked %0d results over %0d limit writes: %0d adds kept, %0d refused",
               sb.results_checked, sb.limits_written, sb.adds_taken, sb.adds_refused);
      $display("%0d trims, %0d entries dropped, %0d lookups found, %0d not found",
               sb.trims, sb.entries_dropped, sb.lookups_hit, sb.lookups_missed);
      if (sb.errors == 0) begin
         $display("epoch_history_table test passed");
      end else begin
         $display("epoch_history_table test failed");
      end
      $finish;
   end

endmodule
